### src/error_diffusion_halftoner_top_defines.svh
// Assertion macros used by the halftoner checker.
`ifndef ERROR_DIFFUSION_HALFTONER_TOP_DEFINES_SVH
`define ERROR_DIFFUSION_HALFTONER_TOP_DEFINES_SVH

// Clocked assertion, ignored while reset is high.
`define EDH_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define EDH_ASSERT_ANY(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/edh_pkg.sv
// Shared constants and types of the error diffusion halftoner.
package edh_pkg;

   // default parameter values
   localparam int MAX_WIDTH_DEFAULT = 1024;
   localparam int FRAC_BITS_DEFAULT = 4;

   // field widths
   localparam int SAMPLE_W    = 8;
   localparam int COLUMN_W    = 10;
   localparam int ROW_WIDTH_W = 11;
   localparam int THRESHOLD_W = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 11;

   // integer bits of an error value, sign included
   localparam int INT_BITS = 10;

   // register reset values
   localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET  = 11'd512;
   localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET  = 8'd127;
   localparam logic                   SERPENTINE_RESET = 1'b1;

   // full-on dot level and the shift of the 1/16 weights
   localparam logic [SAMPLE_W-1:0] DOT_LEVEL    = 8'd255;
   localparam int                  WEIGHT_SHIFT = 4;

   // the line store keeps at most this many words (one valid bit each)
   localparam int LINE_WORDS_MAX = 256;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ROW_WIDTH  = 2'd0,
      CSR_THRESHOLD  = 2'd1,
      CSR_SERPENTINE = 2'd2
   } csr_index_type;

endpackage

### src/error_diffusion_halftoner_top.sv
// Floyd-Steinberg error diffusion halftoner, one 8-bit channel, streamed.
//
// Requests (req_*) carry one sample of the next visited pixel; req_image_start
// marks the first pixel of an image and clears the error line, the carried
// errors, the column counter and the scan direction. Each request gives one
// response (rsp_*): the dot, the pixel's column and a row-end flag.
// Configuration (csr_*) writes row_width, threshold and serpentine; it is
// always ready outside reset. Write it only while no request is open; the
// block itself does not enforce this.
//
// A request is registered together with the line store read of its column;
// the sum, threshold and error split then run on that stage and land in the
// response register. One request per cycle is taken while rsp_ready is
// high; the line store has one write and one read port and the row-end
// write of the last column is replayed in the following cycle, when the row's
// first pixel never writes. Writes not yet visible to a read are forwarded.
// A stalled response holds; the request stage then keeps one more request
// and req_ready drops only when both are full. Reset clears the pipeline,
// the registers to their defaults and all line valid bits at once; the line
// store itself is not swept, a word whose valid bit is low reads as zero.
module error_diffusion_halftoner_top import edh_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT,
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SAMPLE_W-1:0]    req_sample,
   input  logic                   req_image_start,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_dot,
   output logic [COLUMN_W-1:0]    rsp_column,
   output logic                   rsp_row_end,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   // error word: sign plus integer bits plus fraction
   localparam int E        = FRAC_BITS + INT_BITS;
   localparam int SW       = E + 2;          // sample plus two errors
   localparam int WIDE     = E + 4;          // error times 7
   localparam int COL_BITS = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int CMP_W    = ($clog2(MAX_WIDTH + 1) > ROW_WIDTH_W) ?
                             $clog2(MAX_WIDTH + 1) : ROW_WIDTH_W;
   // line store banking: columns interleave over lanes, one valid bit per word
   localparam int LANE_BITS = $clog2((MAX_WIDTH + LINE_WORDS_MAX - 1) / LINE_WORDS_MAX);
   localparam int LANES     = 1 << LANE_BITS;
   localparam int WORDS     = (MAX_WIDTH + LANES - 1) / LANES;
   localparam int WORD_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int LANE_W    = (LANE_BITS > 0) ? LANE_BITS : 1;

   localparam logic signed [WIDE-1:0] SAT_HI = {5'b00000, {(E-1){1'b1}}};
   localparam logic signed [WIDE-1:0] SAT_LO = {5'b11111, {(E-1){1'b0}}};

   function automatic logic signed [E-1:0] sat_e(input logic signed [WIDE-1:0] v);
      logic signed [WIDE-1:0] r;
      r = v;
      if (v > SAT_HI) r = SAT_HI;
      if (v < SAT_LO) r = SAT_LO;
      return r[E-1:0];
   endfunction

   // ---------------------------------------------------------------- config
   logic [ROW_WIDTH_W-1:0] row_width_ff;
   logic [THRESHOLD_W-1:0] threshold_ff;
   logic                   serpentine_ff;

   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff  <= ROW_WIDTH_RESET;
         threshold_ff  <= THRESHOLD_RESET;
         serpentine_ff <= SERPENTINE_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_ROW_WIDTH:  row_width_ff  <= csr_data[ROW_WIDTH_W-1:0];
            CSR_THRESHOLD:  threshold_ff  <= csr_data[THRESHOLD_W-1:0];
            CSR_SERPENTINE: serpentine_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // row width clamped to 2..MAX_WIDTH, kept as last column index
   logic [CMP_W-1:0]    width_raw;
   logic [COL_BITS-1:0] width_m1;

   assign width_raw = CMP_W'(row_width_ff);

   always_comb begin
      if (width_raw < CMP_W'(2)) begin
         width_m1 = COL_BITS'(1);
      end else if (width_raw > CMP_W'(MAX_WIDTH)) begin
         width_m1 = COL_BITS'(MAX_WIDTH - 1);
      end else begin
         width_m1 = COL_BITS'(width_raw - CMP_W'(1));
      end
   end

   // ------------------------------------------------- scan position at accept
   // The column sequence does not depend on pixel data, so it is worked out
   // when a request is taken and the line store read starts right away.
   logic                accept;
   logic                clear;
   logic [COL_BITS-1:0] cnt_ff, cnt_in, cnt_use;
   logic                rev_ff, rev_in, rev_use;
   logic                last_use;
   logic [COL_BITS-1:0] col_use, behind_use;

   assign accept = req_valid && req_ready;
   assign clear  = accept && req_image_start;

   always_comb begin
      cnt_use    = req_image_start ? '0 : ((cnt_ff > width_m1) ? width_m1 : cnt_ff);
      rev_use    = req_image_start ? 1'b0 : rev_ff;
      last_use   = (cnt_use == width_m1);
      col_use    = rev_use ? (width_m1 - cnt_use) : cnt_use;
      behind_use = rev_use ? (col_use + COL_BITS'(1)) : (col_use - COL_BITS'(1));
      cnt_in     = last_use ? '0 : (cnt_use + COL_BITS'(1));
      rev_in     = last_use ? (serpentine_ff & ~rev_use) : rev_use;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rev_ff <= 1'b0;
      end else if (accept) begin
         cnt_ff <= cnt_in;
         rev_ff <= rev_in;
      end
   end

   // ----------------------------------------------------------- stage one
   logic                s1_valid_ff;
   logic [SAMPLE_W-1:0] s1_sample_ff;
   logic                s1_start_ff;
   logic [COL_BITS-1:0] s1_col_ff;
   logic [COL_BITS-1:0] s1_behind_ff;
   logic                s1_has_behind_ff;
   logic                s1_last_ff;
   logic [LANE_W-1:0]   s1_lane_ff;
   logic                s1_rd_valid_ff;
   logic                s1_fwd_hit_ff;
   logic signed [E-1:0] s1_fwd_data_ff;
   logic                s1_advance;

   logic                rsp_valid_ff;
   logic                rsp_dot_ff;
   logic [COLUMN_W-1:0] rsp_column_ff;
   logic                rsp_row_end_ff;

   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !reset && (!s1_valid_ff || s1_advance);

   // carried errors
   logic signed [E-1:0] ahead_ff;
   logic signed [E-1:0] pend_behind_ff;
   logic signed [E-1:0] pend_below_ff;

   // line store read data, one register per lane
   logic signed [E-1:0] rd_data_ff [LANES];

   // replayed row-end write of the last column
   logic                dw_valid_ff, dw_valid_in;
   logic [COL_BITS-1:0] dw_col_ff;
   logic signed [E-1:0] dw_data_ff;

   // arithmetic
   logic signed [E-1:0]    line_val, ahead_val, pb_val, pbb_val;
   logic signed [SW-1:0]   sum;
   logic signed [E-1:0]    total;
   logic signed [E-1:0]    thr_fx;
   logic signed [E-1:0]    dot_fx;
   logic                   dot;
   logic signed [E:0]      err;
   logic signed [WIDE-1:0] err_w, p7, p5, p3;
   logic signed [E-1:0]    a7, b1, b5, b3;
   logic signed [E-1:0]    behind_data;
   logic signed [E-1:0]    new_behind;

   assign thr_fx = $signed(E'({threshold_ff, {FRAC_BITS{1'b0}}}));
   assign dot_fx = $signed(E'({DOT_LEVEL, {FRAC_BITS{1'b0}}}));

   always_comb begin
      // an image start sees a cleared line and no carried error
      if (s1_start_ff) begin
         line_val = '0;
      end else if (s1_fwd_hit_ff) begin
         line_val = s1_fwd_data_ff;
      end else if (s1_rd_valid_ff) begin
         line_val = rd_data_ff[s1_lane_ff];
      end else begin
         line_val = '0;
      end
      ahead_val = s1_start_ff ? '0 : ahead_ff;
      pb_val    = s1_start_ff ? '0 : pend_below_ff;
      pbb_val   = s1_start_ff ? '0 : pend_behind_ff;

      sum   = $signed(SW'({s1_sample_ff, {FRAC_BITS{1'b0}}})) + SW'(line_val) + SW'(ahead_val);
      total = sat_e(WIDE'(sum));
      dot   = (total > thr_fx);
      err   = (E+1)'(total) - (dot ? (E+1)'(dot_fx) : '0);

      // 7/16, 1/16, 5/16, 3/16, each floored
      err_w = WIDE'(err);
      p7    = (err_w <<< 3) - err_w;
      p5    = (err_w <<< 2) + err_w;
      p3    = (err_w <<< 1) + err_w;
      a7    = sat_e(p7 >>> WEIGHT_SHIFT);
      b1    = sat_e(err_w >>> WEIGHT_SHIFT);
      b5    = sat_e(p5 >>> WEIGHT_SHIFT);
      b3    = sat_e(p3 >>> WEIGHT_SHIFT);

      behind_data = sat_e(WIDE'(pbb_val) + WIDE'(b3));
      new_behind  = sat_e(WIDE'(pb_val) + WIDE'(b5));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ahead_ff       <= '0;
         pend_behind_ff <= '0;
         pend_below_ff  <= '0;
      end else if (s1_advance) begin
         if (s1_last_ff) begin
            ahead_ff       <= '0;
            pend_behind_ff <= '0;
            pend_below_ff  <= '0;
         end else begin
            ahead_ff       <= a7;
            pend_behind_ff <= new_behind;
            pend_below_ff  <= b1;
         end
      end
   end

   // ------------------------------------------------------------ line store
   logic                wr_en;
   logic [COL_BITS-1:0] wr_col;
   logic signed [E-1:0] wr_data;
   logic [WORD_W-1:0]   wr_word;
   logic [LANE_W-1:0]   wr_lane;
   logic                wr_word_valid;
   logic [WORD_W-1:0]   rd_word;
   logic [LANE_W-1:0]   rd_lane;
   logic [WORDS-1:0]    valid_ff;

   always_comb begin
      // the row's first pixel never writes, so the replay slot is free
      if (s1_advance && s1_has_behind_ff) begin
         wr_en   = 1'b1;
         wr_col  = s1_behind_ff;
         wr_data = behind_data;
      end else begin
         wr_en   = dw_valid_ff;
         wr_col  = dw_col_ff;
         wr_data = dw_data_ff;
      end
      // writes of the old image are dropped when a new one starts
      if (clear) wr_en = 1'b0;
   end

   assign wr_word       = WORD_W'(wr_col >> LANE_BITS);
   assign wr_lane       = LANE_W'(wr_col & COL_BITS'(LANES - 1));
   assign wr_word_valid = valid_ff[wr_word];
   assign rd_word       = WORD_W'(col_use >> LANE_BITS);
   assign rd_lane       = LANE_W'(col_use & COL_BITS'(LANES - 1));

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_word] <= 1'b1;
      end
   end

   // first write into an invalid word zeroes its other lanes
   for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic signed [E-1:0] bank [WORDS];
      logic                lane_sel;
      logic                lane_we;
      logic signed [E-1:0] lane_wdata;

      assign lane_sel   = (wr_lane == LANE_W'(l));
      assign lane_we    = wr_en && (!wr_word_valid || lane_sel);
      assign lane_wdata = lane_sel ? wr_data : '0;

      always_ff @(posedge clock) begin
         if (lane_we) begin
            bank[wr_word] <= lane_wdata;
         end
         if (accept) begin
            rd_data_ff[l] <= bank[rd_word];
         end
      end
   end

   assign dw_valid_in = s1_advance && s1_last_ff && !clear;

   always_ff @(posedge clock) begin
      if (reset) begin
         dw_valid_ff <= 1'b0;
      end else begin
         dw_valid_ff <= dw_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && s1_last_ff) begin
         dw_col_ff  <= s1_col_ff;
         dw_data_ff <= new_behind;
      end
   end

   // ------------------------------------------------------------ forwarding
   // Writes issued in the accept cycle, or replayed in the next, are not in
   // the read data; catch them by address.
   logic                fwd_hit_in;
   logic signed [E-1:0] fwd_data_in;

   always_comb begin
      fwd_hit_in  = 1'b0;
      fwd_data_in = dw_data_ff;
      if (dw_valid_ff && (dw_col_ff == col_use)) begin
         fwd_hit_in  = 1'b1;
         fwd_data_in = dw_data_ff;
      end
      if (s1_advance && s1_has_behind_ff && (s1_behind_ff == col_use)) begin
         fwd_hit_in  = 1'b1;
         fwd_data_in = behind_data;
      end
      if (s1_advance && s1_last_ff && (s1_col_ff == col_use)) begin
         fwd_hit_in  = 1'b1;
         fwd_data_in = new_behind;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sample_ff     <= req_sample;
         s1_start_ff      <= req_image_start;
         s1_col_ff        <= col_use;
         s1_behind_ff     <= behind_use;
         s1_has_behind_ff <= (cnt_use != '0);
         s1_last_ff       <= last_use;
         s1_lane_ff       <= rd_lane;
         s1_rd_valid_ff   <= valid_ff[rd_word];
         s1_fwd_hit_ff    <= fwd_hit_in;
         s1_fwd_data_ff   <= fwd_data_in;
      end
   end

   // ------------------------------------------------------- response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_dot_ff     <= dot;
         rsp_column_ff  <= COLUMN_W'(s1_col_ff);
         rsp_row_end_ff <= s1_last_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_dot     = rsp_dot_ff;
   assign rsp_column  = rsp_column_ff;
   assign rsp_row_end = rsp_row_end_ff;

endmodule

### src/edh_checker.sv
// Port-level checks of the halftoner and their binding to the top level.
`include "error_diffusion_halftoner_top_defines.svh"

module edh_checker import edh_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic                rsp_dot,
   input logic [COLUMN_W-1:0] rsp_column,
   input logic                rsp_row_end
);

   `EDH_ASSERT_ANY(a_reset_empty, clock, reset |=> !rsp_valid, "response valid after reset")

   // a fresh response follows an accepted request through stage one
   `EDH_ASSERT(a_two_cycle, clock, reset, $rose(rsp_valid) |-> $past(req_valid && req_ready, 2), "response without request two cycles before")

   // a draining output never blocks the input side
   `EDH_ASSERT(a_no_bubble, clock, reset, rsp_ready |-> req_ready, "request blocked while response side drains")

   `EDH_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_dot) && $stable(rsp_column) && $stable(rsp_row_end), "stalled response changed")

endmodule

bind error_diffusion_halftoner_top edh_checker u_edh_checker (.*);

### tb/sv/tb_top.sv
// Self-checking testbench for the error diffusion halftoner: directed plan, then random images.
module tb_top;
   import edh_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Error words: FRAC_BITS fraction bits plus INT_BITS integer bits, sign included.
   localparam int FRAC        = FRAC_BITS_DEFAULT;
   localparam int ERR_W       = INT_BITS + FRAC;
   localparam int LINE_LEN    = MAX_WIDTH_DEFAULT;
   localparam int ERR_MAX     = (1 << (ERR_W - 1)) - 1;
   localparam int ERR_MIN     = -(1 << (ERR_W - 1));
   localparam int PIXEL_COUNT = 1050;
   // Slowest correct run: ~1100 requests, each up to the longest send gap plus the
   // longest response stall plus the pipeline, and a drain per register write.
   localparam int CYCLE_LIMIT = 500_000;
   localparam int PLAN_ROWS   = 34;

   typedef logic signed [ERR_W-1:0] err_type;

   typedef struct packed {
      logic                dot;
      logic [COLUMN_W-1:0] column;
      logic                row_end;
   } pixel_out_type;

   // One step of the opening plan: either a register write or a request.
   // Requests with typed_ok set carry a hand-derived response.
   typedef struct packed {
      bit                    is_csr;
      csr_index_type         reg_sel;
      logic [CSR_DATA_W-1:0] reg_value;
      logic [SAMPLE_W-1:0]   pix;
      logic                  start;
      bit                    typed_ok;
      pixel_out_type         typed;
   } plan_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [SAMPLE_W-1:0]    req_sample = '0;
   logic                   req_image_start = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic                   rsp_dot;
   logic [COLUMN_W-1:0]    rsp_column;
   logic                   rsp_row_end;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // Predictor copy of the registers and the diffusion state.
   logic [ROW_WIDTH_W-1:0] cfg_row_width;
   logic [THRESHOLD_W-1:0] cfg_threshold;
   logic                   cfg_serpentine;
   err_type                line_err [LINE_LEN];
   err_type                ahead_err;
   err_type                behind_part;
   err_type                below_part;
   int unsigned            col_count;
   bit                     rev_row;

   pixel_out_type dots_due [$];   // expected responses, oldest first
   pixel_out_type want_px;
   int            faults = 0;
   int            pixels_sent = 0;
   int            cycle_count = 0;
   int            hold_left = 0;
   bit            steady_flow = 1'b0;   // set for stretches with no idling on either side

   // Directed opening. Starts from reset values: width 512, threshold 127, serpentine on.
   plan_row_type opening_plan [PLAN_ROWS] = '{
      // full-scale sample on image start: dot set, zero error carried
      '{1'b0, CSR_ROW_WIDTH,  11'd0,    8'd255, 1'b1, 1'b1, '{1'b1, 10'd0,    1'b0}},
      '{1'b0, CSR_ROW_WIDTH,  11'd0,    8'd0,   1'b0, 1'b1, '{1'b0, 10'd1,    1'b0}},
      // width shrunk under the count: this pixel becomes the row end
      '{1'b1, CSR_ROW_WIDTH,  11'd2,    8'd0,   1'b0, 1'b0, '0},
      '{1'b0, CSR_ROW_WIDTH,  11'd0,    8'd0,   1'b0, 1'b1, '{1'b0, 10'd1,    1'b1}},
      // reverse row at full width starts in the top column
      '{1'b1, CSR_ROW_WIDTH,  11'd1024, 8'd0,   1'b0, 1'b0, '0},
      '{1'b0, CSR_ROW_WIDTH,  11'd0,    8'd255, 1'b0, 1'b1, '{1'b1, 10'd1023, 1'b0}},
      // width above the maximum clamps to the maximum
      '{1'b1, CSR_ROW_WIDTH,  11'd2047, 8'd0,   1'b0, 1'b0, '0},
      '{1'b0, CSR_ROW_WIDTH,  11'd0,    8'd0,   1'b0, 1'b0, '0},
      // threshold extremes: strict compare
      '{1'b1, CSR_THRESHOLD,  11'd255,  8'd0,   1'b0, 1'b0, '0},
      '{1'b0, CSR_ROW_WIDTH,  11'd0,    8'd255, 1'b1, 1'b1, '{1'b0, 10'd0,    1'b0}},
      '{1'b1, CSR_THRESHOLD,  11'd0,    8'd0,   1'b0, 1'b0, '0},
      '{1'b0, CSR_ROW_WIDTH,  11'd0,    8'd0,   1'b1, 1'b1, '{1'b0, 10'd0,    1'b0}},
      '{1'b0, CSR_ROW_WIDTH,  11'd0,    8'd1,   1'b0, 1'b1, '{1'b1, 10'd1,    1'b0}},
      // width below two acts as two; serpentine two-pixel rows
      '{1'b1, CSR_ROW_WIDTH,  11'd0,    8'd0,   1'b0, 1'b0, '0},
      '{1'b1, CSR_THRESHOLD,  11'd127,  8'd0,   1'b0, 1'b0, '0},
      '{1'b0, CSR_ROW_WIDTH,  11'd0,    8'd200, 1'b1, 1'b1, '{1'b1, 10'd0,    1'b0}},
      '{1'b0, CSR_ROW_WIDTH,  11'd0,    8'd10,  1'b0, 1'b0, '0},
      '{1'b0, CSR_ROW_WIDTH,  11'd0,    8'd77,  1'b0, 1'b0, '0},
      '{1'b0, CSR_ROW_WIDTH,  11'd0,    8'd128, 1'b0, 1'b0, '0},
      // serpentine off: every row left to right
      '{1'b1, CSR_SERPENTINE, 11'd0,    8'd0,   1'b0, 1'b0, '0},
      '{1'b1, CSR_ROW_WIDTH,  11'd1,    8'd0,   1'b0, 1'b0, '0},
      '{1'b0, CSR_ROW_WIDTH,  11'd0,    8'd0,   1'b0, 1'b0, '0},
      '{1'b0, CSR_ROW_WIDTH,  11'd0,    8'd255, 1'b0, 1'b0, '0},
      '{1'b0, CSR_ROW_WIDTH,  11'd0,    8'd128, 1'b0, 1'b0, '0},
      // serpentine dropped in the middle of a reverse row
      '{1'b1, CSR_SERPENTINE, 11'd1,    8'd0,   1'b0, 1'b0, '0},
      '{1'b1, CSR_ROW_WIDTH,  11'd3,    8'd0,   1'b0, 1'b0, '0},
      '{1'b0, CSR_ROW_WIDTH,  11'd0,    8'd90,  1'b1, 1'b0, '0},
      '{1'b0, CSR_ROW_WIDTH,  11'd0,    8'd160, 1'b0, 1'b0, '0},
      '{1'b0, CSR_ROW_WIDTH,  11'd0,    8'd30,  1'b0, 1'b0, '0},
      '{1'b0, CSR_ROW_WIDTH,  11'd0,    8'd250, 1'b0, 1'b0, '0},
      '{1'b1, CSR_SERPENTINE, 11'd0,    8'd0,   1'b0, 1'b0, '0},
      '{1'b0, CSR_ROW_WIDTH,  11'd0,    8'd5,   1'b0, 1'b0, '0},
      '{1'b0, CSR_ROW_WIDTH,  11'd0,    8'd128, 1'b0, 1'b0, '0},
      '{1'b0, CSR_ROW_WIDTH,  11'd0,    8'd64,  1'b0, 1'b0, '0}
   };

   error_diffusion_halftoner_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample      (req_sample),
      .req_image_start (req_image_start),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_dot         (rsp_dot),
      .rsp_column      (rsp_column),
      .rsp_row_end     (rsp_row_end),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic err_type clamp_err(input int v);
      if (v > ERR_MAX) return err_type'(ERR_MAX);
      if (v < ERR_MIN) return err_type'(ERR_MIN);
      return err_type'(v);
   endfunction

   // floor(e * w / 16); arithmetic shift of a signed int rounds toward minus infinity
   function automatic int weigh(input int e, input int w);
      return (e * w) >>> WEIGHT_SHIFT;
   endfunction

   function automatic void clear_image();
      foreach (line_err[i]) line_err[i] = '0;
      ahead_err   = '0;
      behind_part = '0;
      below_part  = '0;
      col_count   = 0;
      rev_row     = 1'b0;
   endfunction

   // Threshold one pixel and diffuse its error; returns the response it must give.
   function automatic pixel_out_type shade_pixel(input logic [SAMPLE_W-1:0] s,
                                                 input logic st);
      int unsigned   w, cnt, col;
      int            total, err, a7, b1, b5, b3;
      err_type       new_behind;
      bit            is_dot, last;
      pixel_out_type res;
      if (st) clear_image();
      w = 32'(cfg_row_width);
      if (w < 2) w = 2;
      if (w > LINE_LEN) w = LINE_LEN;
      cnt = col_count;
      if (cnt > w - 1) cnt = w - 1;           // width shrunk under the count
      col = rev_row ? (w - 1 - cnt) : cnt;

      total  = int'(clamp_err((int'(s) <<< FRAC) + int'(line_err[col]) + int'(ahead_err)));
      is_dot = total > (int'(cfg_threshold) <<< FRAC);
      err    = total - (is_dot ? (int'(DOT_LEVEL) <<< FRAC) : 0);
      a7 = weigh(err, 7);
      b1 = weigh(err, 1);
      b5 = weigh(err, 5);
      b3 = weigh(err, 3);

      // below-behind part finishes the column just passed; dropped at row start
      if (cnt > 0) line_err[rev_row ? col + 1 : col - 1] = clamp_err(int'(behind_part) + b3);
      new_behind = clamp_err(int'(below_part) + b5);

      last = (cnt == w - 1);
      if (last) begin
         line_err[col] = new_behind;
         ahead_err     = '0;
         behind_part   = '0;
         below_part    = '0;
         col_count     = 0;
         rev_row       = cfg_serpentine ? !rev_row : 1'b0;
      end else begin
         ahead_err   = clamp_err(a7);
         behind_part = new_behind;
         below_part  = clamp_err(b1);
         col_count   = cnt + 1;
      end

      res.dot     = is_dot;
      res.column  = col[COLUMN_W-1:0];
      res.row_end = last;
      return res;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int idle_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 48);
   endfunction

   task automatic wait_drained();
      while (dots_due.size() != 0) @(posedge clock);
   endtask

   // Register writes only land with the pipeline empty. csr_valid stays high after
   // the handshake so back-to-back writes never lower and raise it in one step;
   // the next request lowers it.
   task automatic write_reg(input csr_index_type sel, input logic [CSR_DATA_W-1:0] value);
      req_valid <= 1'b0;
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= sel;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (sel)
         CSR_ROW_WIDTH:  cfg_row_width  = value[ROW_WIDTH_W-1:0];
         CSR_THRESHOLD:  cfg_threshold  = value[THRESHOLD_W-1:0];
         CSR_SERPENTINE: cfg_serpentine = value[0];
         default: ;
      endcase
   endtask

   // Send one pixel request; queue the typed response if given, else the predicted one.
   task automatic push_pixel(input logic [SAMPLE_W-1:0] s, input logic st,
                             input bit typed_ok = 1'b0, input pixel_out_type typed = '0);
      pixel_out_type guess;
      int            gap;
      gap = steady_flow ? 0 : idle_len();
      csr_valid <= 1'b0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_sample      <= s;
      req_image_start <= st;
      do @(posedge clock); while (!req_ready);
      guess = shade_pixel(s, st);
      dots_due.push_back(typed_ok ? typed : guess);
      pixels_sent++;
   endtask

   function automatic void note_fault(input string msg);
      faults++;
      if (faults <= 10) $display("%0t ns: %s", $time, msg);
   endfunction

   // ---------------------------------------------------------------- response side

   // Checks every accepted response against the oldest expectation, then picks
   // the next cycle's rsp_ready from a random stall counter.
   always @(posedge clock) begin
      if (reset) begin
         hold_left = 0;
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (dots_due.size() == 0) begin
               note_fault($sformatf("unexpected response: dot %0b column %0d row_end %0b",
                                    rsp_dot, rsp_column, rsp_row_end));
            end else begin
               want_px = dots_due.pop_front();
               if (rsp_dot !== want_px.dot || rsp_column !== want_px.column ||
                   rsp_row_end !== want_px.row_end)
                  note_fault($sformatf({"response mismatch: expected dot %0b column %0d ",
                                        "row_end %0b, got dot %0b column %0d row_end %0b"},
                                       want_px.dot, want_px.column, want_px.row_end,
                                       rsp_dot, rsp_column, rsp_row_end));
            end
         end
         if (hold_left > 0) hold_left--;
         else if (!steady_flow && $urandom_range(0, 5) == 0) hold_left = idle_len();
         rsp_ready <= (hold_left == 0);
      end
   end

   // Watchdog: a hung handshake or a lost response ends here.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TB_ERROR");
      $finish;
   end

   // ---------------------------------------------------------------- main sequence

   initial begin
      int                    run_len, mode, pick, roll;
      logic [SAMPLE_W-1:0]   base, stride, s;
      logic                  st;
      csr_index_type         sel;
      logic [CSR_DATA_W-1:0] value;

      // predictor starts from the register defaults and a clear image
      cfg_row_width  = ROW_WIDTH_RESET;
      cfg_threshold  = THRESHOLD_RESET;
      cfg_serpentine = SERPENTINE_RESET;
      clear_image();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed part: edges of every field and the named corner cases
      foreach (opening_plan[i]) begin
         if (opening_plan[i].is_csr)
            write_reg(opening_plan[i].reg_sel, opening_plan[i].reg_value);
         else
            push_pixel(opening_plan[i].pix, opening_plan[i].start,
                       opening_plan[i].typed_ok, opening_plan[i].typed);
      end

      // random part: phases of retuning, then runs of pixels with varied content
      while (pixels_sent < PIXEL_COUNT) begin
         steady_flow = ($urandom_range(0, 3) == 0);

         if ($urandom_range(0, 9) < 6) begin
            // retune at least one register, mostly small widths so rows wrap often
            pick = $urandom_range(0, 2);
            for (int r = 0; r < 3; r++) begin
               if (r == pick || $urandom_range(0, 1) == 1) begin
                  sel  = csr_index_type'(r);
                  roll = $urandom_range(0, 99);
                  case (sel)
                     CSR_ROW_WIDTH: begin
                        if (roll < 70)      value = CSR_DATA_W'($urandom_range(2, 24));
                        else if (roll < 78) value = CSR_DATA_W'($urandom_range(0, 1));
                        else if (roll < 88) value = CSR_DATA_W'($urandom_range(25, 300));
                        else if (roll < 94) value = CSR_DATA_W'($urandom_range(1000, 1024));
                        else                value = CSR_DATA_W'($urandom_range(1025, 2047));
                     end
                     CSR_THRESHOLD: begin
                        if (roll < 10)      value = '0;
                        else if (roll < 20) value = CSR_DATA_W'(255);
                        else                value = CSR_DATA_W'($urandom_range(0, 255));
                     end
                     default: value = CSR_DATA_W'($urandom_range(0, 1));
                  endcase
                  write_reg(sel, value);
               end
            end
         end else if ($urandom_range(0, 4) == 0) begin
            // hold the sender until the pipeline has emptied
            req_valid <= 1'b0;
            wait_drained();
         end

         run_len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 40) : $urandom_range(41, 150);
         mode    = $urandom_range(0, 3);
         base    = SAMPLE_W'($urandom_range(0, 255));
         stride  = SAMPLE_W'($urandom_range(0, 7));
         for (int k = 0; k < run_len; k++) begin
            case (mode)
               0:       s = SAMPLE_W'($urandom_range(0, 255));
               1:       s = base;                              // flat field
               2:       s = SAMPLE_W'(base + stride * k);      // ramp, wraps
               default: s = ($urandom_range(0, 1) == 1) ? 8'd255 : 8'd0;
            endcase
            // most runs open a new image; a stray image start now and then
            st = (k == 0 && mode != 3) || ($urandom_range(0, 49) == 0);
            push_pixel(s, st);
         end
      end

      req_valid <= 1'b0;
      wait_drained();
      repeat (8) @(posedge clock);   // catch any stray response past the last one
      if (faults == 0 && dots_due.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
